// File: rtl/sbpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpg_pkg: shared types and constants
// Register indexes, field widths and the sequencer state type for the
// signature bit position generator.
// ----------------------------------------------------------------------------
package sbpg_pkg;

  // Field and register widths
  localparam int KeyW      = 32;
  localparam int PosW      = 16;
  localparam int NumW      = 6;
  localparam int CountW    = 7;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 16;
  localparam int OutDataW  = 24;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] RegSigLength    = 2'd0;
  localparam logic [CfgAddrW-1:0] RegBitsPerValue = 2'd1;
  localparam logic [CfgAddrW-1:0] RegIndexMode    = 2'd2;

  // Reset values of the registers
  localparam logic [PosW-1:0]   SigLengthReset    = 16'd64;
  localparam logic [CountW-1:0] BitsPerValueReset = 7'd4;

  // Smallest usable signature length
  localparam logic [PosW-1:0] MinSigLength = 16'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD_LEN,
    ST_MOD_STEP,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/signature_bit_position_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_bit_position_generator_unit: Bloom-style signature positions
// Takes one key per beat and emits a run of signature bit positions built
// by double hashing: start = key mod L, step = 1 + key mod (L-1).
// ----------------------------------------------------------------------------
// Each key gives bits_per_value positions, capped at MAX_POSITIONS. A
// single compare-and-subtract unit does all the work: it runs one restoring
// remainder pass of one key bit per cycle for key mod L, a second pass for
// key mod (L-1), and then one modular add per emitted position. The input
// is not ready until the last position of a run has been handed to the
// output register; that register lets the final position wait while the
// next key is taken. Positions appear on m_tdata in order, with m_tlast on
// the final one. A bits_per_value of zero gives no beats, and a sig_length
// below 2 is used as 2.
module signature_bit_position_generator_unit #(
  parameter int KEY_WIDTH     = 32,
  parameter int MAX_POSITIONS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [sbpg_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [sbpg_pkg::CfgDataW-1:0] cfg_wdata,
  // Key input; tdata: key_value[31:0]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sbpg_pkg::KeyW-1:0]     s_tdata,
  // Position output; tdata: bit_position[15:0], position_number[21:16],
  // zero fill[23:22]; tlast: last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sbpg_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tlast
);
  import sbpg_pkg::*;

  // Used key width and bit counter width
  localparam int KW   = (KEY_WIDTH < KeyW) ? KEY_WIDTH : KeyW;
  localparam int BitW = (KW > 1) ? $clog2(KW) : 1;
  localparam logic [BitW-1:0]   BitTop = BitW'(KW - 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_POSITIONS);

  // Configuration registers
  logic [PosW-1:0]   sig_length;
  logic [CountW-1:0] bits_per_value;
  logic              index_mode;

  // Sequencer and datapath registers
  state_t            state, state_next;
  logic [KW-1:0]     key;
  logic [BitW-1:0]   bit_idx;
  logic [PosW-1:0]   rem;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   stride;
  logic [CountW-1:0] idx;

  // Output register
  logic [PosW-1:0]   out_pos;
  logic [NumW-1:0]   out_num;
  logic              out_last;

  // Derived configuration
  logic [PosW-1:0]   len_eff;
  logic [PosW-1:0]   len_m1;
  logic [CountW-1:0] count_eff;

  // Shared compare-and-subtract unit
  logic [PosW:0]     unit_a;
  logic [PosW:0]     unit_d;
  logic [PosW:0]     unit_y;

  logic              s_acc;
  logic              slot_free;
  logic              emit_last;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_length     <= SigLengthReset;
      bits_per_value <= BitsPerValueReset;
      index_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegSigLength:    sig_length     <= cfg_wdata;
        RegBitsPerValue: bits_per_value <= cfg_wdata[CountW-1:0];
        RegIndexMode:    index_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp length and count
  assign len_eff   = (sig_length < MinSigLength) ? MinSigLength : sig_length;
  assign len_m1    = len_eff - PosW'(1);
  assign count_eff = (bits_per_value > MaxCount) ? MaxCount : bits_per_value;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign emit_last = (idx == count_eff - CountW'(1));

  // Feed the shared unit: remainder step while dividing, modular add while emitting
  always_comb begin
    case (state)
      ST_MOD_LEN: begin
        unit_a = {rem, key[bit_idx]};
        unit_d = {1'b0, len_eff};
      end
      ST_MOD_STEP: begin
        unit_a = {rem, key[bit_idx]};
        unit_d = {1'b0, len_m1};
      end
      default: begin
        unit_a = {1'b0, pos} + {1'b0, stride};
        unit_d = {1'b0, len_eff};
      end
    endcase
    unit_y = (unit_a >= unit_d) ? (unit_a - unit_d) : unit_a;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) state_next = ST_MOD_LEN;
      end
      ST_MOD_LEN: begin
        if (bit_idx == '0) state_next = ST_MOD_STEP;
      end
      ST_MOD_STEP: begin
        if (bit_idx == '0) begin
          state_next = (count_eff == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: capture key, step the remainder passes, advance the position
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          key     <= s_tdata[KW-1:0];
          bit_idx <= BitTop;
          rem     <= '0;
        end
      end
      ST_MOD_LEN: begin
        bit_idx <= bit_idx - BitW'(1);
        rem     <= unit_y[PosW-1:0];
        if (bit_idx == '0) begin
          pos     <= unit_y[PosW-1:0];
          rem     <= '0;
          bit_idx <= BitTop;
        end
      end
      ST_MOD_STEP: begin
        bit_idx <= bit_idx - BitW'(1);
        rem     <= unit_y[PosW-1:0];
        if (bit_idx == '0) begin
          stride <= unit_y[PosW-1:0] + PosW'(1);
          idx    <= '0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          pos <= unit_y[PosW-1:0];
          idx <= idx + CountW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: load a beat whenever the slot is free during emission
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_pos  <= index_mode ? stride : pos;
      out_num  <= idx[NumW-1:0];
      out_last <= emit_last;
    end
  end

  assign m_tdata = {{(OutDataW - PosW - NumW){1'b0}}, out_num, out_pos};
  assign m_tlast = out_last;

  // Emitted double-hash position stays below the signature length
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !index_mode) |-> (out_pos < len_eff))
    else $error("bit position not below signature length");

  // Running position stays reduced while emitting
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (pos < len_eff && stride <= len_eff - PosW'(1)))
    else $error("running position or step out of range");

  // Accepted key starts the first remainder pass
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (state == ST_MOD_LEN && bit_idx == BitTop && rem == '0))
    else $error("key accept did not start remainder pass");

  // Last flag lands on the final ordinal of the run
  a_last_num: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (CountW'(out_num) == count_eff - CountW'(1)))
    else $error("last flag on wrong ordinal");

endmodule

// File: tb/signature_bit_position_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_bit_position_generator_unit_tb: self-checking bench
// Drives keys through the input stream under several signature settings and
// predicts each run of double-hashing bit positions in the bench itself.
// Every output beat is checked field by field against the oldest pending
// position. The key stream goes in random bursts and the output side stalls
// on its own pattern.
// ----------------------------------------------------------------------------
module signature_bit_position_generator_unit_tb;
  import sbpg_pkg::*;

  localparam int MaxPos      = 64;
  localparam int SettleCycles = 160;
  localparam int LimitCycles  = 1500000;
  localparam int RandomPhases = 8;
  localparam int KeysPerPhase = 50;

  // Index with no register behind it
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;

  // Output side stall patterns
  typedef enum int {RX_STREAM, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

  typedef struct {
    logic [PosW-1:0] bit_position;
    logic [NumW-1:0] position_number;
    logic            last;
  } sig_pos_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [KeyW-1:0]     s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  // Mirror of the configuration registers
  logic [PosW-1:0]   cur_sig_length;
  logic [CountW-1:0] cur_bits_per_value;
  logic              cur_index_mode;

  sig_pos_t pending_positions[$];
  int       mismatch_count;
  int       burst_left;
  int       cycle_count;

  signature_bit_position_generator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LimitCycles) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("** signature_bit_position_generator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Effective modulus: short signatures are raised to the minimum
  function automatic logic [31:0] eff_length();
    return (cur_sig_length < MinSigLength) ? 32'(MinSigLength) : 32'(cur_sig_length);
  endfunction

  // Queue the run of positions that one accepted key produces
  function automatic void predict_positions(input logic [KeyW-1:0] key);
    logic [31:0] len;
    logic [31:0] stride;
    logic [31:0] pos;
    int          count;
    sig_pos_t    item;
    len    = eff_length();
    count  = (cur_bits_per_value > MaxPos) ? MaxPos : int'(cur_bits_per_value);
    pos    = key % len;
    stride = 32'd1 + key % (len - 32'd1);
    for (int i = 0; i < count; i++) begin
      item.bit_position    = cur_index_mode ? stride[PosW-1:0] : pos[PosW-1:0];
      item.position_number = i[NumW-1:0];
      item.last            = (i + 1 == count);
      pending_positions.push_back(item);
      pos = pos + stride;
      if (pos >= len) pos = pos - len;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Check each output beat against the oldest pending position
  always @(posedge clk) begin
    sig_pos_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch("beat with nothing pending", 32'(m_tdata), 32'd0);
      end else begin
        want = pending_positions.pop_front();
        if (m_tdata[PosW-1:0] !== want.bit_position)
          flag_mismatch("bit_position", 32'(m_tdata[PosW-1:0]),
                        32'(want.bit_position));
        if (m_tdata[PosW+NumW-1:PosW] !== want.position_number)
          flag_mismatch("position_number", 32'(m_tdata[PosW+NumW-1:PosW]),
                        32'(want.position_number));
        if (m_tlast !== want.last)
          flag_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Output side: stall on one of four patterns, picked again at random after each span
  initial begin
    rx_pattern_t pattern;
    int          span;
    m_tready = 1'b0;
    forever begin
      pattern = rx_pattern_t'($urandom_range(0, 3));
      span    = $urandom_range(20, 200);
      for (int n = 0; n < span; n++) begin
        @(negedge clk);
        case (pattern)
          RX_STREAM:   m_tready <= 1'b1;
          RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: m_tready <= (n % 4) != 3;
          default:     m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Send one key; called and returning at a falling edge, tvalid held high
  task automatic send_key(input logic [KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_positions(key);
    @(negedge clk);
  endtask

  // Drop tvalid, drain all pending positions and let any zero-count key finish
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // One register write, with cfg_we dropped again before returning; the block must be idle
  task automatic write_reg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      RegSigLength:    cur_sig_length     = data;
      RegBitsPerValue: cur_bits_per_value = data[CountW-1:0];
      RegIndexMode:    cur_index_mode     = data[0];
      default:         ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] sig_len,
                           input logic [CfgDataW-1:0] bits,
                           input logic [CfgDataW-1:0] mode);
    settle();
    write_reg(RegSigLength, sig_len);
    write_reg(RegBitsPerValue, bits);
    write_reg(RegIndexMode, mode);
  endtask

  // Keys biased toward small values and multiples of the modulus
  function automatic logic [KeyW-1:0] pick_key();
    logic [31:0] len;
    len = eff_length();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 2 * len);
      1:       return $urandom_range(0, 65535) * len + $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_config();
    send_key(32'd0);
    send_key(32'd1000);
  endtask

  task automatic test_key_extremes();
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h7FFF_FFFF);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
  endtask

  // Short signatures are raised to two; also the longest ones
  task automatic test_sig_length_extremes();
    logic [CfgDataW-1:0] lengths[6];
    lengths = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65534, 16'd65535};
    foreach (lengths[j]) begin
      write_all(lengths[j], 16'd6, CfgDataW'(j % 2));
      send_key($urandom);
    end
  endtask

  // Zero count gives no beats, counts above the cap saturate
  task automatic test_count_extremes();
    logic [CfgDataW-1:0] counts[5];
    counts = '{16'd0, 16'd1, 16'd64, 16'd65, 16'd127};
    foreach (counts[j]) begin
      write_all(16'd65535, counts[j], 16'd0);
      send_key($urandom);
    end
  endtask

  // A write to the unused index must leave every register alone
  task automatic test_unknown_register();
    write_all(16'd37, 16'd5, 16'd0);
    write_reg(RegUnused, 16'hFFFF);
    send_key(32'hDEAD_BEEF);
  endtask

  task automatic test_random_traffic();
    logic [CfgDataW-1:0] sig_len;
    logic [CfgDataW-1:0] bits;
    logic [CfgDataW-1:0] mode;
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 3))
        0:       sig_len = CfgDataW'($urandom_range(0, 3));
        1:       sig_len = CfgDataW'($urandom_range(4, 64));
        2:       sig_len = CfgDataW'($urandom_range(65534, 65535));
        default: sig_len = CfgDataW'($urandom_range(65, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       bits = 16'd0;
        1:       bits = CfgDataW'($urandom_range(9, 64));
        2:       bits = CfgDataW'($urandom_range(65, 127));
        3:       bits = CfgDataW'($urandom_range(0, 65535));
        default: bits = CfgDataW'($urandom_range(1, 8));
      endcase
      mode = CfgDataW'($urandom_range(0, 65535));
      // pin the extremes in the first two phases
      if (p == 0) begin
        sig_len = 16'd2;
        bits    = 16'd1;
      end else if (p == 1) begin
        sig_len = 16'd65535;
        bits    = 16'd64;
      end
      write_all(sig_len, bits, mode);
      write_reg(RegUnused, CfgDataW'($urandom_range(0, 65535)));
      for (int k = 0; k < KeysPerPhase; k++) send_key(pick_key());
    end
  endtask

  // Main sequence
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    s_tvalid           = 1'b0;
    s_tdata            = '0;
    cur_sig_length     = SigLengthReset;
    cur_bits_per_value = BitsPerValueReset;
    cur_index_mode     = 1'b0;
    mismatch_count     = 0;
    burst_left         = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_config();
    test_key_extremes();
    test_sig_length_extremes();
    test_count_extremes();
    test_unknown_register();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("** signature_bit_position_generator_unit: PASSED **");
    end else begin
      $display("** signature_bit_position_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
